FILE: sv/eci_pkg.sv
`default_nettype none
package eci_pkg;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [1:0] {
        K_INOUT4 = 2'd0,
        K_OUT3   = 2'd1,
        K_IN4    = 2'd2,
        K_RSVD   = 2'd3
    } t_kind;

    localparam int QUEUE_DEPTH = 4;
endpackage
`default_nettype wire

FILE: sv/eci_front.sv
`default_nettype none
// Front: restoring divider pipeline, one quotient bit per stage.
module eci_front #(
    parameter int FRAC_BITS = eci_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [1:0]            i_kind,
    input  wire logic [15:0]           i_elapsed,
    input  wire logic [15:0]           i_duration,
    input  wire logic signed [15:0]    i_start_value,
    input  wire logic signed [15:0]    i_end_value,
    input  wire logic                  i_stall,
    output logic                       o_valid,
    output logic [1:0]                 o_kind,
    output logic [FRAC_BITS:0]         o_t,
    output logic signed [15:0]         o_start_value,
    output logic signed [15:0]         o_end_value
);
    import eci_pkg::*;

    localparam int NS = FRAC_BITS;

    // per-stage pipeline registers
    logic [NS:0]              r_v;
    logic [1:0]               r_kind  [NS+1];
    logic                     r_full  [NS+1];
    logic [16:0]              r_rem   [NS+1];
    logic [15:0]              r_den   [NS+1];
    logic [FRAC_BITS-1:0]     r_q     [NS+1];
    logic signed [15:0]       r_sv    [NS+1];
    logic signed [15:0]       r_ev    [NS+1];

    logic [16:0] n_rem [NS];
    logic        n_bit [NS];

    // trial subtract per stage
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            logic [17:0] sh;
            sh = {r_rem[k], 1'b0};
            if (sh >= {2'b00, r_den[k]}) begin
                n_bit[k] = 1'b1;
                n_rem[k] = 17'(sh - {2'b00, r_den[k]});
            end else begin
                n_bit[k] = 1'b0;
                n_rem[k] = sh[16:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (!i_stall) begin
            r_v <= {r_v[NS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            r_kind[0] <= i_kind;
            r_full[0] <= (i_duration == 16'd0) || (i_elapsed >= i_duration);
            r_rem[0]  <= {1'b0, i_elapsed};
            r_den[0]  <= i_duration;
            r_q[0]    <= '0;
            r_sv[0]   <= i_start_value;
            r_ev[0]   <= i_end_value;
            for (int k = 0; k < NS; k++) begin
                r_kind[k+1] <= r_kind[k];
                r_full[k+1] <= r_full[k];
                r_rem[k+1]  <= n_rem[k];
                r_den[k+1]  <= r_den[k];
                r_q[k+1]    <= {r_q[k][FRAC_BITS-2:0], n_bit[k]};
                r_sv[k+1]   <= r_sv[k];
                r_ev[k+1]   <= r_ev[k];
            end
        end
    end

    assign o_valid       = r_v[NS];
    assign o_kind        = r_kind[NS];
    assign o_t           = r_full[NS] ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, r_q[NS]};
    assign o_start_value = r_sv[NS];
    assign o_end_value   = r_ev[NS];
endmodule
`default_nettype wire

FILE: sv/eci_queue.sv
`default_nettype none
// Small FIFO between divider and curve pipeline.
module eci_queue #(
    parameter int W = 8,
    parameter int DEPTH = eci_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic              o_afull,
    output logic [W-1:0]      o_data
);
    import eci_pkg::*;

    localparam int AW = $clog2(DEPTH);
    logic [W-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= AW'(r_wp + 1'b1);
            if (i_pop)  r_rp <= AW'(r_rp + 1'b1);
            r_cnt <= (AW+1)'(r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    // almost full: asserts when only one free slot remains
    assign o_afull = (r_cnt >= (AW+1)'(DEPTH - 1));
endmodule
`default_nettype wire

FILE: sv/eci_back.sv
`default_nettype none
// Back: curve evaluation and blend, at most one multiply per stage, never stalls.
module eci_back #(
    parameter int FRAC_BITS = eci_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [1:0]         i_kind,
    input  wire logic [FRAC_BITS:0] i_t,
    input  wire logic signed [15:0] i_start_value,
    input  wire logic signed [15:0] i_end_value,
    output logic                    o_valid,
    output logic signed [15:0]      o_value
);
    import eci_pkg::*;

    localparam int TW = FRAC_BITS + 1;
    localparam logic [TW-1:0] ONE  = TW'(1) << FRAC_BITS;
    localparam logic [TW-1:0] HALF = TW'(1) << (FRAC_BITS - 1);

    function automatic logic [TW-1:0] fxm(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [2*TW-1:0] p;
        p = a * b;
        return TW'(p >> FRAC_BITS);
    endfunction

    logic [4:0] r_v;
    // stage 1: choose operand x (t or 1-t)
    logic [1:0] r1_k; logic r1_hi; logic [TW-1:0] r1_x;
    logic signed [15:0] r1_s, r1_e;
    // stage 2: s = x*x
    logic [1:0] r2_k; logic r2_hi; logic [TW-1:0] r2_x, r2_s;
    logic signed [15:0] r2_s0, r2_e;
    // stage 3: s*s or s*x, then f
    logic [TW-1:0] r3_f;
    logic signed [15:0] r3_s0; logic signed [16:0] r3_d;
    // stage 4: blend product
    logic signed [TW+17:0] r4_sum;
    logic signed [15:0] r5_val;

    logic [TW-1:0] n_p3, n_f;
    logic signed [TW+17:0] n_sum, n_neg;

    always_comb begin
        n_p3 = (r2_k == K_OUT3) ? fxm(r2_s, r2_x) : fxm(r2_s, r2_s);
        case (r2_k)
            K_INOUT4: n_f = r2_hi ? TW'(ONE - TW'({n_p3, 3'b000})) : TW'({n_p3, 3'b000});
            K_OUT3:   n_f = TW'(ONE - n_p3);
            default:  n_f = n_p3;
        endcase
        n_sum = ((TW+18)'(r3_s0) <<< FRAC_BITS)
                + ((TW+18)'($signed({1'b0, r3_f})) * (TW+18)'(r3_d));
        n_neg = -r4_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[3:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        r1_k  <= i_kind;
        r1_hi <= (i_t >= HALF);
        r1_x  <= ((i_kind == K_OUT3) || (i_kind == K_INOUT4 && i_t >= HALF))
                 ? TW'(ONE - i_t) : i_t;
        r1_s  <= i_start_value;
        r1_e  <= i_end_value;

        r2_k  <= r1_k; r2_hi <= r1_hi; r2_x <= r1_x;
        r2_s  <= fxm(r1_x, r1_x);
        r2_s0 <= r1_s; r2_e <= r1_e;

        r3_f  <= n_f;
        r3_s0 <= r2_s0;
        r3_d  <= 17'(r2_e) - 17'(r2_s0);

        r4_sum <= n_sum;

        r5_val <= r4_sum[TW+17] ? 16'(-(n_neg >>> FRAC_BITS))
                                : 16'(r4_sum >>> FRAC_BITS);
    end

    assign o_valid = r_v[4];
    assign o_value = r5_val;
endmodule
`default_nettype wire

FILE: sv/easing_curve_interpolator_unit.sv
`default_nettype none
// Easing curve interpolator. One item per cycle: busy rises only when the
// queue between the divider and the curve pipeline nears full, which never
// happens here since the back end cannot be stalled by the receiver.
// Each item passes the divider stages (one quotient bit per stage), then
// the queue, then five curve/blend stages; o_valid strobes once.
module easing_curve_interpolator_unit #(
    parameter int FRAC_BITS = eci_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_kind,
    input  wire logic [15:0]        i_elapsed,
    input  wire logic [15:0]        i_duration,
    input  wire logic signed [15:0] i_start_value,
    input  wire logic signed [15:0] i_end_value,
    output logic                    o_valid,
    output logic signed [15:0]      o_value
);
    import eci_pkg::*;

    localparam int QW = 2 + FRAC_BITS + 1 + 32;

    logic f_v; logic [1:0] f_k; logic [FRAC_BITS:0] f_t;
    logic signed [15:0] f_s, f_e;
    logic q_empty, q_afull, q_pop;
    logic [QW-1:0] q_out;
    logic r_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_take <= 1'b0;
        else          r_take <= start && !busy;
    end

    assign busy = q_afull;

    eci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid(start && !busy),
        .i_kind, .i_elapsed, .i_duration, .i_start_value, .i_end_value,
        .i_stall(1'b0), .o_valid(f_v), .o_kind(f_k), .o_t(f_t),
        .o_start_value(f_s), .o_end_value(f_e)
    );

    eci_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_q (
        .i_clk, .i_rst_n, .i_push(f_v), .i_data({f_k, f_t, f_s, f_e}),
        .i_pop(q_pop), .o_empty(q_empty), .o_afull(q_afull), .o_data(q_out)
    );

    assign q_pop = !q_empty;

    eci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_pop),
        .i_kind(q_out[QW-1 -: 2]), .i_t(q_out[32 +: FRAC_BITS+1]),
        .i_start_value(q_out[31:16]), .i_end_value(q_out[15:0]),
        .o_valid, .o_value
    );

    a_nopopempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("pop from empty queue");
    a_nooverflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_afull && f_v && !q_pop)) else $error("queue overflow");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_take) else $error("accept lost");
endmodule
`default_nettype wire
